[design/balist_pkg.sv]
`timescale 1ns / 1ps

package balist_pkg;

  // List size and derived widths
  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;

  // Command codes
  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_REMOVE = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_FIND   = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // Status codes
  localparam logic [2:0] STAT_DONE   = 3'd0;
  localparam logic [2:0] STAT_AT_END = 3'd1;
  localparam logic [2:0] STAT_FULL   = 3'd2;
  localparam logic [2:0] STAT_MISS   = 3'd3;
  localparam logic [2:0] STAT_BADPOS = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         position;
    logic signed [31:0] element_key;
    logic [31:0]        element_payload;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] found_key;
    logic [31:0]        found_payload;
    logic [7:0]         list_length;
    logic               list_full;
    logic               list_empty;
  } out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
  } entry_t;

  // Port group from the sequencer to the entry memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_PUT,
    S_FIN
  } seq_state_t;

endpackage

[design/bounded_array_list_engine_core.sv]
`timescale 1ns / 1ps

// Channel   Signals           Handshake
// command   req (in_t)        taken when start is high and busy is low
// result    rsp (out_t)       valid for one cycle while done is high
//
// Append, insert past the end, bad, full or empty-list requests: done in the cycle after the command word.
// Other commands step through S_SCAN, S_DRAIN, S_PUT (insert only) and S_FIN;
// remove at the end goes straight to S_FIN.
// One entry moves per cycle through the single read port of the entry memory.
// Reset clears the entry count; the entry memory is not cleared.
// The result side cannot stall; busy holds off new commands.
module bounded_array_list_engine_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  balist_pkg::in_t  req,
  output logic             busy,
  output logic             done,
  output balist_pkg::out_t rsp
);
  import balist_pkg::*;

  mem_req_t mreq;
  entry_t   rdata;
  logic     res_valid;
  out_t     res;

  balist_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  balist_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // Hold the result word for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= res;
  end

  // A result only follows a taken command or ongoing work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result word without a command");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.list_full && rsp.list_empty))
    else $error("list both full and empty");

  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_DONE) |-> (rsp.found_key == '0 && rsp.found_payload == '0))
    else $error("found fields set on failed command");

  // The result word only comes out once the command is finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while a command is in work");

endmodule

[design/balist_mem.sv]
`timescale 1ns / 1ps

module balist_mem (
  input  logic                clk,
  input  balist_pkg::mem_req_t mreq,
  output balist_pkg::entry_t   rdata
);
  import balist_pkg::*;

  entry_t mem [CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata <= mem[mreq.raddr];
    end
  end

endmodule

[design/balist_seq.sv]
`timescale 1ns / 1ps

module balist_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  balist_pkg::in_t      req,
  output logic                 busy,
  output logic                 res_valid,
  output balist_pkg::out_t     res,
  output balist_pkg::mem_req_t mreq,
  input  balist_pkg::entry_t   rdata
);
  import balist_pkg::*;

  seq_state_t       state, state_next;
  logic [2:0]       op, op_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [IDX_W-1:0] last, last_next;
  logic             rd_v;
  logic [IDX_W-1:0] rd_a;
  logic [CNT_W-1:0] w, w_next;
  logic             hit, hit_next;
  logic [31:0]      fkey, fkey_next;
  logic [31:0]      fpay, fpay_next;
  logic [CNT_W-1:0] count, count_next;
  logic [31:0]      tkey, tkey_next;
  logic [31:0]      tpay, tpay_next;

  logic [CMP_W-1:0] pos_x, cnt_x, pm1, len_x;
  logic [CNT_W-1:0] cnt_m1;
  logic             is_full, bad_pos, key_eq;

  assign pos_x   = CMP_W'(req.position);
  assign cnt_x   = CMP_W'(count);
  assign pm1     = pos_x - CMP_W'(1);
  assign cnt_m1  = count - CNT_W'(1);
  assign is_full = (count == CNT_W'(CAPACITY));
  assign bad_pos = (pos_x == '0) || (pos_x > cnt_x);
  // Shared key comparator
  assign key_eq  = (rdata.key == tkey);
  assign busy    = (state != S_IDLE);

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rd_v  <= mreq.re;
    end
  end

  always_ff @(posedge clk) begin
    op   <= op_next;
    cur  <= cur_next;
    last <= last_next;
    rd_a <= mreq.raddr;
    w    <= w_next;
    hit  <= hit_next;
    fkey <= fkey_next;
    fpay <= fpay_next;
    tkey <= tkey_next;
    tpay <= tpay_next;
  end

  // Next state, memory access and result
  always_comb begin
    state_next = state;
    op_next    = op;
    cur_next   = cur;
    last_next  = last;
    w_next     = w;
    hit_next   = hit;
    fkey_next  = fkey;
    fpay_next  = fpay;
    count_next = count;
    tkey_next  = tkey;
    tpay_next  = tpay;
    mreq       = '0;
    res_valid  = 1'b0;
    res        = '0;

    // Consume the word read in the previous cycle
    if (rd_v && (state == S_SCAN || state == S_DRAIN)) begin
      case (op)
        CMD_INSERT: begin
          mreq.we    = 1'b1;
          mreq.waddr = rd_a + IDX_W'(1);
          mreq.wdata = rdata;
        end
        CMD_REMOVE: begin
          mreq.we    = 1'b1;
          mreq.waddr = rd_a - IDX_W'(1);
          mreq.wdata = rdata;
        end
        CMD_DELETE: begin
          if (!key_eq) begin
            mreq.we    = 1'b1;
            mreq.waddr = w[IDX_W-1:0];
            mreq.wdata = rdata;
            w_next     = w + CNT_W'(1);
          end
        end
        CMD_FIND: begin
          if (key_eq && !hit) begin
            hit_next  = 1'b1;
            fkey_next = rdata.key;
            fpay_next = rdata.payload;
          end
        end
        CMD_READ: begin
          fkey_next = rdata.key;
          fpay_next = rdata.payload;
        end
        default: ;
      endcase
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next   = req.cmd;
          tkey_next = req.element_key;
          tpay_next = req.element_payload;
          hit_next  = 1'b0;
          w_next    = '0;
          fkey_next = '0;
          fpay_next = '0;
          res.status = STAT_DONE;
          unique case (req.cmd)
            CMD_APPEND: begin
              res_valid = 1'b1;
              if (is_full) begin
                res.status = STAT_FULL;
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = count[IDX_W-1:0];
                mreq.wdata = {req.element_key, req.element_payload};
                count_next = count + CNT_W'(1);
              end
            end
            CMD_INSERT: begin
              if (is_full) begin
                res_valid  = 1'b1;
                res.status = STAT_FULL;
              end else if (pos_x == '0) begin
                res_valid  = 1'b1;
                res.status = STAT_BADPOS;
              end else if (pos_x > cnt_x) begin
                res_valid  = 1'b1;
                res.status = STAT_AT_END;
                mreq.we    = 1'b1;
                mreq.waddr = count[IDX_W-1:0];
                mreq.wdata = {req.element_key, req.element_payload};
                count_next = count + CNT_W'(1);
              end else begin
                cur_next   = cnt_m1[IDX_W-1:0];
                last_next  = pm1[IDX_W-1:0];
                state_next = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (bad_pos) begin
                res_valid  = 1'b1;
                res.status = STAT_BADPOS;
              end else if (pos_x == cnt_x) begin
                state_next = S_FIN;
              end else begin
                cur_next   = pos_x[IDX_W-1:0];
                last_next  = cnt_m1[IDX_W-1:0];
                state_next = S_SCAN;
              end
            end
            CMD_DELETE, CMD_FIND: begin
              if (count == '0) begin
                res_valid  = 1'b1;
                res.status = STAT_MISS;
              end else begin
                cur_next   = '0;
                last_next  = cnt_m1[IDX_W-1:0];
                state_next = S_SCAN;
              end
            end
            CMD_READ: begin
              if (bad_pos) begin
                res_valid  = 1'b1;
                res.status = STAT_BADPOS;
              end else begin
                cur_next   = pm1[IDX_W-1:0];
                last_next  = pm1[IDX_W-1:0];
                state_next = S_SCAN;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; insert walks down, all else walks up
        mreq.re    = 1'b1;
        mreq.raddr = cur;
        if (cur == last) begin
          state_next = S_DRAIN;
        end else if (op == CMD_INSERT) begin
          cur_next = cur - IDX_W'(1);
        end else begin
          cur_next = cur + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_next = (op == CMD_INSERT) ? S_PUT : S_FIN;
      end
      S_PUT: begin
        // Drop the new entry into the opened slot
        mreq.we    = 1'b1;
        mreq.waddr = last;
        mreq.wdata = {tkey, tpay};
        state_next = S_FIN;
      end
      S_FIN: begin
        res_valid  = 1'b1;
        state_next = S_IDLE;
        res.status = STAT_DONE;
        case (op)
          CMD_INSERT: count_next = count + CNT_W'(1);
          CMD_REMOVE: count_next = cnt_m1;
          CMD_DELETE: begin
            count_next = w;
            if (w == count) begin
              res.status = STAT_MISS;
            end
          end
          CMD_FIND: begin
            if (hit) begin
              res.found_key     = fkey;
              res.found_payload = fpay;
            end else begin
              res.status = STAT_MISS;
            end
          end
          CMD_READ: begin
            res.found_key     = fkey;
            res.found_payload = fpay;
          end
          default: ;
        endcase
      end
      default: state_next = S_IDLE;
    endcase

    len_x           = CMP_W'(count_next);
    res.list_length = len_x[7:0];
    res.list_full   = (count_next == CNT_W'(CAPACITY));
    res.list_empty  = (count_next == '0);
  end

endmodule
